// ----- hdl/greedy_point_interval_matcher_unit_macros.svh -----
// Assertion macros for the greedy point/interval matcher.
// Used by the datapath; no other dependencies.
`ifndef GREEDY_POINT_INTERVAL_MATCHER_UNIT_MACROS_SVH
`define GREEDY_POINT_INTERVAL_MATCHER_UNIT_MACROS_SVH

// ante implies cons in the same cycle
`define GPIM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpim assertion failed");

// ante implies cons in the next cycle
`define GPIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpim assertion failed");

`endif

// ----- hdl/gpim_pkg.sv -----
// Shared types and constants for the greedy point/interval matcher.
// No dependencies.
package gpim_pkg;

	localparam logic [1:0] OP_LOAD_PT = 2'd0;
	localparam logic [1:0] OP_LOAD_IV = 2'd1;
	localparam logic [1:0] OP_RUN     = 2'd2;

	localparam int MATCH_W   = 11;
	localparam int MATCH_MAX = 2047;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value_a;
		logic [31:0] value_b;
	} in_item_t;

	typedef struct packed {
		logic [MATCH_W-1:0] match_count;
		logic               dropped;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic iscan_start;
		logic iscan_step;
		logic mark_iv;
		logic pscan_start;
		logic pscan_step;
		logic take_pt;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic iscan_idle;
		logic pscan_idle;
		logic iv_found;
		logic pt_found;
	} dp_stat_t;

endpackage

// ----- hdl/gpim_req_if.sv -----
// Request channel: valid/ready handshake carrying one input item.
// Depends on gpim_pkg.
interface gpim_req_if;
	logic               valid;
	logic               ready;
	gpim_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gpim_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result item.
// Depends on gpim_pkg.
interface gpim_rsp_if;
	logic                valid;
	logic                ready;
	gpim_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gpim_dp.sv -----
// Datapath: point and interval memories, scan counters, best-candidate registers.
// Depends on gpim_pkg and greedy_point_interval_matcher_unit_macros.svh.
`include "greedy_point_interval_matcher_unit_macros.svh"

module gpim_dp #(
	parameter int MAX_POINTS    = 1024,
	parameter int MAX_INTERVALS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gpim_pkg::dp_cmd_t   cmd,
	input  gpim_pkg::in_item_t  in_item,
	output gpim_pkg::dp_stat_t  stat,
	output gpim_pkg::out_item_t result
);
	localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int IAW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int ICW = $clog2(MAX_INTERVALS + 1);

	logic [31:0] pt_val_mem  [MAX_POINTS];
	logic        pt_used_mem [MAX_POINTS];
	logic [63:0] iv_mem      [MAX_INTERVALS];
	logic        iv_done_mem [MAX_INTERVALS];

	logic [PCW-1:0] np_q, kp_q;
	logic [ICW-1:0] ni_q, ki_q, match_q;
	logic           ovf_q;

	logic           irv_s1, prv_s1;
	logic [IAW-1:0] iidx_s1;
	logic [PAW-1:0] pidx_s1;
	logic [63:0]    iv_s1;
	logic           iv_done_s1;
	logic [31:0]    pt_s1;
	logic           pt_used_s1;

	logic           ifound_q, pfound_q;
	logic [63:0]    ibest_q;
	logic [IAW-1:0] ibest_idx_q;
	logic [31:0]    pbest_q;
	logic [PAW-1:0] pbest_idx_q;
	gpim_pkg::out_item_t res_q;

	logic pt_full, iv_full, i_more, p_more, i_cand, p_cand;

	assign pt_full = (np_q == PCW'(MAX_POINTS));
	assign iv_full = (ni_q == ICW'(MAX_INTERVALS));
	assign i_more  = (ki_q < ni_q);
	assign p_more  = (kp_q < np_q);
	assign i_cand  = irv_s1 && !iv_done_s1 && (!ifound_q || (iv_s1 < ibest_q));
	assign p_cand  = prv_s1 && !pt_used_s1 && (pt_s1 >= ibest_q[31:0])
		&& (pt_s1 <= ibest_q[63:32]) && (!pfound_q || (pt_s1 < pbest_q));

	// point memories
	always_ff @(posedge clk) begin
		if (cmd.load && in_item.op == gpim_pkg::OP_LOAD_PT && !pt_full) begin
			pt_val_mem[np_q[PAW-1:0]]  <= in_item.value_a;
			pt_used_mem[np_q[PAW-1:0]] <= 1'b0;
		end else if (cmd.take_pt) begin
			pt_used_mem[pbest_idx_q] <= 1'b1;
		end
		pt_s1      <= pt_val_mem[kp_q[PAW-1:0]];
		pt_used_s1 <= pt_used_mem[kp_q[PAW-1:0]];
		pidx_s1    <= kp_q[PAW-1:0];
	end

	// interval memories, end in the upper half
	always_ff @(posedge clk) begin
		if (cmd.load && in_item.op == gpim_pkg::OP_LOAD_IV && !iv_full) begin
			iv_mem[ni_q[IAW-1:0]]      <= {in_item.value_b, in_item.value_a};
			iv_done_mem[ni_q[IAW-1:0]] <= 1'b0;
		end else if (cmd.mark_iv) begin
			iv_done_mem[ibest_idx_q] <= 1'b1;
		end
		iv_s1      <= iv_mem[ki_q[IAW-1:0]];
		iv_done_s1 <= iv_done_mem[ki_q[IAW-1:0]];
		iidx_s1    <= ki_q[IAW-1:0];
	end

	always_ff @(posedge clk) begin
		if (i_cand && cmd.iscan_step) begin
			ibest_q     <= iv_s1;
			ibest_idx_q <= iidx_s1;
		end
		if (p_cand && cmd.pscan_step) begin
			pbest_q     <= pt_s1;
			pbest_idx_q <= pidx_s1;
		end
		if (cmd.finish) begin
			res_q.match_count <= (32'(match_q) > 32'(gpim_pkg::MATCH_MAX))
				? gpim_pkg::MATCH_W'(gpim_pkg::MATCH_MAX)
				: gpim_pkg::MATCH_W'(match_q);
			res_q.dropped <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q     <= '0;
			ni_q     <= '0;
			ovf_q    <= 1'b0;
			match_q  <= '0;
			ki_q     <= '0;
			kp_q     <= '0;
			irv_s1   <= 1'b0;
			prv_s1   <= 1'b0;
			ifound_q <= 1'b0;
			pfound_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (in_item.op == gpim_pkg::OP_LOAD_PT) begin
					if (pt_full) ovf_q <= 1'b1;
					else np_q <= np_q + 1'b1;
				end else begin
					if (iv_full) ovf_q <= 1'b1;
					else ni_q <= ni_q + 1'b1;
				end
			end
			if (cmd.iscan_start) begin
				ki_q     <= '0;
				irv_s1   <= 1'b0;
				ifound_q <= 1'b0;
			end else if (cmd.iscan_step) begin
				irv_s1 <= i_more;
				if (i_more) ki_q <= ki_q + 1'b1;
				if (i_cand) ifound_q <= 1'b1;
			end
			if (cmd.pscan_start) begin
				kp_q     <= '0;
				prv_s1   <= 1'b0;
				pfound_q <= 1'b0;
			end else if (cmd.pscan_step) begin
				prv_s1 <= p_more;
				if (p_more) kp_q <= kp_q + 1'b1;
				if (p_cand) pfound_q <= 1'b1;
			end
			if (cmd.take_pt) match_q <= match_q + 1'b1;
			if (cmd.finish) begin
				np_q    <= '0;
				ni_q    <= '0;
				ovf_q   <= 1'b0;
				match_q <= '0;
			end
		end
	end

	assign stat.iscan_idle = !i_more && !irv_s1;
	assign stat.pscan_idle = !p_more && !prv_s1;
	assign stat.iv_found   = ifound_q;
	assign stat.pt_found   = pfound_q;
	assign result          = res_q;

	`GPIM_ASSERT_IMPL(a_match_bound, clk, arst_n, 1'b1, match_q <= ni_q)
	`GPIM_ASSERT_IMPL(a_take_found, clk, arst_n, cmd.take_pt, pfound_q && ifound_q)
	`GPIM_ASSERT_NEXT(a_finish_clears, clk, arst_n, cmd.finish, !ovf_q && np_q == '0)

endmodule

// ----- hdl/gpim_ctrl.sv -----
// Controller: sequences interval selection, point search and result handoff.
// Depends on gpim_pkg.
module gpim_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  gpim_pkg::dp_stat_t stat,
	output gpim_pkg::dp_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_ISCAN, S_MARK, S_PSCAN, S_TAKE, S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q, accept, can_out;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_out   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.load        = accept
			&& (in_op inside {gpim_pkg::OP_LOAD_PT, gpim_pkg::OP_LOAD_IV});
		cmd.iscan_start = (accept && in_op == gpim_pkg::OP_RUN) || (state_q == S_TAKE);
		cmd.iscan_step  = (state_q == S_ISCAN);
		cmd.mark_iv     = (state_q == S_MARK);
		cmd.pscan_start = (state_q == S_MARK);
		cmd.pscan_step  = (state_q == S_PSCAN);
		cmd.take_pt     = (state_q == S_TAKE) && stat.pt_found;
		cmd.finish      = (state_q == S_FIN) && can_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && in_op == gpim_pkg::OP_RUN) state_q <= S_ISCAN;
				end
				S_ISCAN: begin
					if (stat.iscan_idle) state_q <= stat.iv_found ? S_MARK : S_FIN;
				end
				S_MARK: begin
					state_q <= S_PSCAN;
				end
				S_PSCAN: begin
					if (stat.pscan_idle) state_q <= S_TAKE;
				end
				S_TAKE: begin
					state_q <= S_ISCAN;
				end
				S_FIN: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/greedy_point_interval_matcher_unit.sv -----
// Greedy point/interval matcher. Load items (points, intervals) are taken one per
// cycle while no run is in progress. A run item repeatedly scans the interval
// memory for the smallest unmatched (end, start) pair, then scans the point memory
// for the smallest unused point inside it; both scans go through single-port
// memories one entry per cycle. Load items are still taken while a finished result
// waits on the response side.
// Depends on gpim_pkg, gpim_req_if, gpim_rsp_if, gpim_ctrl and gpim_dp.
module greedy_point_interval_matcher_unit #(
	parameter int MAX_POINTS    = 1024,
	parameter int MAX_INTERVALS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	gpim_req_if.sink        req,
	gpim_rsp_if.source      rsp
);
	gpim_pkg::dp_cmd_t  cmd;
	gpim_pkg::dp_stat_t stat;

	gpim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.data.op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gpim_dp #(
		.MAX_POINTS    (MAX_POINTS),
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (req.data),
		.stat    (stat),
		.result  (rsp.data)
	);

endmodule

// ----- verif/tb_greedy_point_interval_matcher_unit.sv -----
`timescale 1ns / 1ps
// Testbench for greedy_point_interval_matcher_unit: drives load/run items, predicts
// each run's match count and drop flag, and checks every reported result.
// Depends on gpim_pkg, gpim_req_if, gpim_rsp_if and the matcher RTL.
module tb_greedy_point_interval_matcher_unit;

	localparam int CAPACITY = 1024;
	localparam int TOTAL_ITEMS = 1350;
	localparam int STALL_LIMIT = 4000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	gpim_req_if req ();
	gpim_rsp_if rsp ();

	greedy_point_interval_matcher_unit #(
		.MAX_POINTS(CAPACITY),
		.MAX_INTERVALS(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	gpim_pkg::in_item_t pending_items[$];
	gpim_pkg::out_item_t expected_reports[$];
	logic [31:0] loaded_points[$];
	logic [63:0] loaded_intervals[$];
	logic drop_seen = 1'b0;
	int accepted_items = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic gpim_pkg::out_item_t run_greedy_match();
		gpim_pkg::out_item_t r;
		logic [31:0] pts[$];
		logic [63:0] ivs[$];
		bit taken[];
		int hits;
		int j;
		pts = loaded_points;
		ivs = loaded_intervals;
		pts.sort();
		ivs.sort();
		taken = new[pts.size()];
		hits = 0;
		foreach (ivs[k]) begin
			j = 0;
			while (j < pts.size() && (pts[j] < ivs[k][31:0] || taken[j]))
				j++;
			if (j < pts.size() && pts[j] <= ivs[k][63:32]) begin
				taken[j] = 1'b1;
				hits++;
			end
		end
		if (hits > gpim_pkg::MATCH_MAX)
			hits = gpim_pkg::MATCH_MAX;
		r.match_count = hits[gpim_pkg::MATCH_W-1:0];
		r.dropped = drop_seen;
		return r;
	endfunction

	task automatic predict_item(input gpim_pkg::in_item_t it);
		case (it.op)
			gpim_pkg::OP_LOAD_PT: begin
				if (loaded_points.size() < CAPACITY)
					loaded_points.push_back(it.value_a);
				else
					drop_seen = 1'b1;
			end
			gpim_pkg::OP_LOAD_IV: begin
				if (loaded_intervals.size() < CAPACITY)
					loaded_intervals.push_back({it.value_b, it.value_a});
				else
					drop_seen = 1'b1;
			end
			gpim_pkg::OP_RUN: begin
				expected_reports.push_back(run_greedy_match());
				loaded_points.delete();
				loaded_intervals.delete();
				drop_seen = 1'b0;
			end
			default: ;
		endcase
	endtask

	function automatic int send_idle_pct();
		if (accepted_items < 450)
			return 36;
		if (accepted_items < 900)
			return 88;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (accepted_items < 450)
			return 88;
		if (accepted_items < 900)
			return 36;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
				req.valid <= 1'b1;
				req.data <= pending_items.pop_front();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct());
	end

	// monitor
	always @(posedge clk) begin
		gpim_pkg::out_item_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predict_item(req.data);
				accepted_items <= accepted_items + 1;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: match_count=%0d dropped=%0b",
							rsp.data.match_count, rsp.data.dropped);
				end else begin
					want = expected_reports.pop_front();
					if (rsp.data.match_count !== want.match_count
							|| rsp.data.dropped !== want.dropped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected count=%0d dropped=%0b, got count=%0d dropped=%0b",
								want.match_count, want.dropped,
								rsp.data.match_count, rsp.data.dropped);
					end
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
					|| (pending_items.size() == 0 && !req.valid && expected_reports.size() == 0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
		gpim_pkg::in_item_t it;
		it.op = op;
		it.value_a = a;
		it.value_b = b;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_value(input logic [31:0] base, input bit near);
		if (near)
			return base + $urandom_range(40, 0);
		return $urandom();
	endfunction

	task automatic push_random_set();
		int np;
		int ni;
		int cut;
		bit near;
		logic [31:0] base;
		logic [31:0] s;
		np = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 0);
		ni = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
		near = ($urandom_range(3, 0) != 0);
		base = $urandom();
		cut = $urandom_range(np + ni, 0);
		for (int i = 0; i < np + ni; i++) begin
			if ($urandom_range(29, 0) == 0)
				push_item(OP_UNUSED, $urandom(), $urandom());
			if (i < np) begin
				push_item(gpim_pkg::OP_LOAD_PT, pick_value(base, near), $urandom());
			end else begin
				s = pick_value(base, near);
				if ($urandom_range(9, 0) == 0)
					push_item(gpim_pkg::OP_LOAD_IV, s, pick_value(base, near));
				else
					push_item(gpim_pkg::OP_LOAD_IV, s,
						near ? s + $urandom_range(15, 0) : $urandom());
			end
		end
		// shuffle order of point and interval loads a little
		if (cut > 0 && pending_items.size() > cut) begin
			gpim_pkg::in_item_t t;
			t = pending_items[pending_items.size() - 1];
			pending_items[pending_items.size() - 1] = pending_items[pending_items.size() - cut];
			pending_items[pending_items.size() - cut] = t;
		end
		push_item(gpim_pkg::OP_RUN, $urandom(), $urandom());
	endtask

	task automatic wait_all_reported();
		while (pending_items.size() > 0 || req.valid || expected_reports.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		@(posedge arst_n);

		// directed: empty run, extremes, ties, reversed interval, unused op
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		push_item(gpim_pkg::OP_LOAD_PT, 32'h0, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_LOAD_PT, 32'hFFFF_FFFF, 32'h0);
		push_item(gpim_pkg::OP_LOAD_PT, 32'h10, 32'h0);
		push_item(gpim_pkg::OP_LOAD_PT, 32'h10, 32'h0);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h0, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_LOAD_IV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h20, 32'h5);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h5, 32'h10);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h0, 32'h10);
		push_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_LOAD_PT, 32'h7, 32'h0);
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h7, 32'h7);
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		push_item(gpim_pkg::OP_LOAD_PT, 32'hAAAA_AAAA, 32'h5555_5555);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h5555_5555, 32'hAAAA_AAAA);
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		wait_all_reported();

		while (accepted_items + pending_items.size() < TOTAL_ITEMS - CAPACITY - 6)
			push_random_set();
		wait_all_reported();

		// point store overflow
		for (int i = 0; i <= CAPACITY; i++)
			push_item(gpim_pkg::OP_LOAD_PT, $urandom(), $urandom());
		push_item(gpim_pkg::OP_LOAD_IV, 32'h0, 32'hFFFF_FFFF);
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		push_item(gpim_pkg::OP_LOAD_PT, 32'h3, 32'h0);
		push_item(gpim_pkg::OP_LOAD_IV, 32'h1, 32'h4);
		push_item(gpim_pkg::OP_RUN, 32'h0, 32'h0);
		wait_all_reported();
		repeat (50) @(posedge clk);

		if (mismatches == 0 && expected_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
